[design/gclp_pkg.sv]
// ----------------------------------------------------------------------------
// G-code line parser package
// Shared types, constants and the command name table.
// ----------------------------------------------------------------------------
package gclp_pkg;

	localparam int VALUE_WIDTH   = 32;
	localparam int NUM_COMMANDS  = 15;
	localparam int NUM_LETTERS   = 9;
	localparam int NAME_SLOTS    = 5;

	localparam logic [3:0] UNKNOWN_INDEX = 4'd15;
	localparam logic [3:0] NO_LETTER     = 4'd15;

	typedef enum logic [1:0] {
		PH_BEFORE,
		PH_NAME,
		PH_ARGS
	} token_phase_t;

	typedef enum logic [1:0] {
		NUM_SIGN,
		NUM_DIGITS,
		NUM_DONE
	} number_phase_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_line;
	} char_item_t;

	typedef struct packed {
		logic [3:0]         command_index;
		logic               recognized;
		logic [8:0]         used_mask;
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
		logic signed [31:0] z_value;
		logic signed [31:0] e_value;
		logic signed [31:0] f_value;
		logic signed [31:0] s_value;
		logic signed [31:0] i_value;
		logic signed [31:0] j_value;
		logic signed [31:0] k_value;
	} record_t;

	// name collected from the first token of a line
	typedef struct packed {
		logic            started;
		logic            overflow;
		logic [2:0]      len;
		logic [4:0][7:0] bytes;
	} name_info_t;

	typedef struct packed {
		logic [2:0]      len;
		logic [4:0][7:0] bytes;
	} cmd_entry_t;

	function automatic cmd_entry_t make_entry(input logic [2:0] len, input logic [7:0] c0,
		input logic [7:0] c1, input logic [7:0] c2, input logic [7:0] c3);
		cmd_entry_t e;
		e.len   = len;
		e.bytes = {8'h00, c3, c2, c1, c0};
		return e;
	endfunction

	function automatic cmd_entry_t cmd_entry(input logic [3:0] k);
		cmd_entry_t e;
		case (k)
			4'd0:    e = make_entry(3'd2, "G", "1", 8'h00, 8'h00);
			4'd1:    e = make_entry(3'd2, "G", "2", 8'h00, 8'h00);
			4'd2:    e = make_entry(3'd2, "G", "3", 8'h00, 8'h00);
			4'd3:    e = make_entry(3'd3, "G", "1", "7", 8'h00);
			4'd4:    e = make_entry(3'd3, "G", "1", "8", 8'h00);
			4'd5:    e = make_entry(3'd3, "G", "1", "9", 8'h00);
			4'd6:    e = make_entry(3'd3, "G", "2", "8", 8'h00);
			4'd7:    e = make_entry(3'd3, "G", "9", "0", 8'h00);
			4'd8:    e = make_entry(3'd3, "G", "9", "1", 8'h00);
			4'd9:    e = make_entry(3'd3, "G", "9", "2", 8'h00);
			4'd10:   e = make_entry(3'd4, "M", "1", "0", "4");
			4'd11:   e = make_entry(3'd4, "M", "1", "0", "6");
			4'd12:   e = make_entry(3'd4, "M", "1", "0", "9");
			4'd13:   e = make_entry(3'd4, "M", "1", "4", "0");
			4'd14:   e = make_entry(3'd4, "M", "1", "9", "0");
			default: e = make_entry(3'd7, 8'h00, 8'h00, 8'h00, 8'h00);
		endcase
		return e;
	endfunction

	function automatic logic [3:0] letter_code(input logic [7:0] c);
		logic [3:0] r;
		case (c)
			"X":     r = 4'd0;
			"Y":     r = 4'd1;
			"Z":     r = 4'd2;
			"E":     r = 4'd3;
			"F":     r = 4'd4;
			"S":     r = 4'd5;
			"I":     r = 4'd6;
			"J":     r = 4'd7;
			"K":     r = 4'd8;
			default: r = NO_LETTER;
		endcase
		return r;
	endfunction

endpackage

[design/gclp_cmd_match.sv]
// ----------------------------------------------------------------------------
// G-code command matcher
// Compares the collected command name against the fixed command table.
// ----------------------------------------------------------------------------
module gclp_cmd_match (
	input  gclp_pkg::name_info_t name,
	output logic [3:0]           cmd_index
);

	logic [gclp_pkg::NUM_COMMANDS-1:0] hit;

	always_comb begin
		gclp_pkg::cmd_entry_t e;
		for (int k = 0; k < gclp_pkg::NUM_COMMANDS; k++) begin
			e = gclp_pkg::cmd_entry(4'(k));
			hit[k] = name.started && !name.overflow && (name.len == e.len)
				&& (name.bytes == e.bytes);
		end
	end

	always_comb begin
		cmd_index = gclp_pkg::UNKNOWN_INDEX;
		for (int k = gclp_pkg::NUM_COMMANDS - 1; k >= 0; k--) begin
			if (hit[k]) begin
				cmd_index = 4'(k);
			end
		end
	end

endmodule

[design/gclp_lexer.sv]
// ----------------------------------------------------------------------------
// G-code line lexer
// Per-byte token state, number accumulation and parameter registers.
// ----------------------------------------------------------------------------
module gclp_lexer #(
	parameter int VALUE_WIDTH = gclp_pkg::VALUE_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  gclp_pkg::char_item_t item,
	input  logic [3:0]           cmd_index,
	output gclp_pkg::name_info_t name,
	output gclp_pkg::record_t    record
);

	localparam int NL = gclp_pkg::NUM_LETTERS;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [VALUE_WIDTH-1:0] CAP     = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [VALUE_WIDTH-1:0] POS_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

	logic                    in_comment_q;
	gclp_pkg::token_phase_t  phase_q;
	logic                    at_start_q;
	logic [4:0][7:0]         buf_q;
	logic [2:0]              len_q;
	logic                    ovf_q;
	logic [3:0]              letter_q;
	gclp_pkg::number_phase_t num_q;
	logic                    neg_q;
	logic [VALUE_WIDTH-1:0]  acc_q;
	logic [VALUE_WIDTH-1:0]  vals_q [NL];
	logic [NL-1:0]           mask_q;

	logic                    a_comment;
	gclp_pkg::token_phase_t  a_phase;
	logic                    a_start;
	logic [4:0][7:0]         a_buf;
	logic [2:0]              a_len;
	logic                    a_ovf;
	logic [3:0]              a_letter;
	gclp_pkg::number_phase_t a_num;
	logic                    a_neg;
	logic [VALUE_WIDTH-1:0]  a_acc;

	logic                    closing;
	logic                    c_write;
	gclp_pkg::token_phase_t  n_phase;
	logic [VALUE_WIDTH-1:0]  close_val;
	logic [VALUE_WIDTH-1:0]  vals_d [NL];
	logic [NL-1:0]           mask_d;

	logic                    is_sep;
	logic                    is_semi;
	logic                    is_digit;
	logic [VALUE_WIDTH+3:0]  mac;
	logic [VALUE_WIDTH-1:0]  acc_dig;

	logic [7:0] c;
	assign c = item.char_byte;

	assign is_sep   = (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR);
	assign is_semi  = (c == CH_SEMI);
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

	// acc * 10 + digit, saturating at the magnitude cap
	assign mac     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ {{VALUE_WIDTH{1'b0}}, c[3:0]};
	assign acc_dig = (mac > {4'b0, CAP}) ? CAP : mac[VALUE_WIDTH-1:0];

	always_comb begin
		a_comment = in_comment_q;
		a_phase   = phase_q;
		a_start   = at_start_q;
		a_buf     = buf_q;
		a_len     = len_q;
		a_ovf     = ovf_q;
		a_letter  = letter_q;
		a_num     = num_q;
		a_neg     = neg_q;
		a_acc     = acc_q;
		if (!in_comment_q && !is_semi && !is_sep) begin
			if (phase_q == gclp_pkg::PH_BEFORE) begin
				a_phase = gclp_pkg::PH_NAME;
			end
			if (a_phase == gclp_pkg::PH_NAME) begin
				if (len_q < 3'(gclp_pkg::NAME_SLOTS)) begin
					a_buf[len_q] = c;
					a_len        = len_q + 3'd1;
				end else begin
					a_ovf = 1'b1;
				end
			end else if (at_start_q) begin
				a_start  = 1'b0;
				a_letter = gclp_pkg::letter_code(c);
				a_num    = gclp_pkg::NUM_SIGN;
				a_neg    = 1'b0;
				a_acc    = '0;
			end else if (letter_q < 4'(NL)) begin
				case (num_q)
					gclp_pkg::NUM_SIGN: begin
						if (c == CH_TAB || c == CH_VT || c == CH_FF) begin
							a_num = gclp_pkg::NUM_SIGN;
						end else if (c == CH_PLUS) begin
							a_num = gclp_pkg::NUM_DIGITS;
						end else if (c == CH_MINUS) begin
							a_neg = 1'b1;
							a_num = gclp_pkg::NUM_DIGITS;
						end else if (is_digit) begin
							a_acc = acc_dig;
							a_num = gclp_pkg::NUM_DIGITS;
						end else begin
							a_num = gclp_pkg::NUM_DONE;
						end
					end
					gclp_pkg::NUM_DIGITS: begin
						if (is_digit) begin
							a_acc = acc_dig;
						end else begin
							a_num = gclp_pkg::NUM_DONE;
						end
					end
					default: begin
						a_num = num_q;
					end
				endcase
			end
		end
		if (!in_comment_q && is_semi) begin
			a_comment = 1'b1;
		end
	end

	// token close, at most once per byte
	assign closing = item.end_of_line || (!in_comment_q && (is_semi || is_sep));
	assign c_write = closing && (a_phase == gclp_pkg::PH_ARGS) && !a_start
		&& (a_letter < 4'(NL));
	assign n_phase = (closing && a_phase == gclp_pkg::PH_NAME) ? gclp_pkg::PH_ARGS : a_phase;
	assign close_val = a_neg ? (~a_acc + 1'b1) : ((a_acc == CAP) ? POS_MAX : a_acc);

	always_comb begin
		for (int k = 0; k < NL; k++) begin
			vals_d[k] = (c_write && a_letter == 4'(k)) ? close_val : vals_q[k];
			mask_d[k] = mask_q[k] || (c_write && a_letter == 4'(k));
		end
	end

	assign name = '{started: (a_phase != gclp_pkg::PH_BEFORE), overflow: a_ovf,
		len: a_len, bytes: a_buf};

	function automatic logic [31:0] to_field(input logic [VALUE_WIDTH-1:0] v);
		logic [VALUE_WIDTH+31:0] w;
		w = {{32{v[VALUE_WIDTH-1]}}, v};
		return w[31:0];
	endfunction

	always_comb begin
		record.command_index = cmd_index;
		record.recognized    = (cmd_index != gclp_pkg::UNKNOWN_INDEX);
		record.used_mask     = mask_d;
		record.x_value       = to_field(vals_d[0]);
		record.y_value       = to_field(vals_d[1]);
		record.z_value       = to_field(vals_d[2]);
		record.e_value       = to_field(vals_d[3]);
		record.f_value       = to_field(vals_d[4]);
		record.s_value       = to_field(vals_d[5]);
		record.i_value       = to_field(vals_d[6]);
		record.j_value       = to_field(vals_d[7]);
		record.k_value       = to_field(vals_d[8]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q <= 1'b0;
			phase_q      <= gclp_pkg::PH_BEFORE;
			at_start_q   <= 1'b1;
			buf_q        <= '0;
			len_q        <= '0;
			ovf_q        <= 1'b0;
			letter_q     <= gclp_pkg::NO_LETTER;
			num_q        <= gclp_pkg::NUM_SIGN;
			neg_q        <= 1'b0;
			acc_q        <= '0;
			mask_q       <= '0;
			for (int k = 0; k < NL; k++) begin
				vals_q[k] <= '0;
			end
		end else if (step) begin
			if (item.end_of_line) begin
				in_comment_q <= 1'b0;
				phase_q      <= gclp_pkg::PH_BEFORE;
				at_start_q   <= 1'b1;
				buf_q        <= '0;
				len_q        <= '0;
				ovf_q        <= 1'b0;
				letter_q     <= gclp_pkg::NO_LETTER;
				num_q        <= gclp_pkg::NUM_SIGN;
				neg_q        <= 1'b0;
				acc_q        <= '0;
				mask_q       <= '0;
				for (int k = 0; k < NL; k++) begin
					vals_q[k] <= '0;
				end
			end else begin
				in_comment_q <= a_comment;
				phase_q      <= n_phase;
				at_start_q   <= closing ? 1'b1 : a_start;
				buf_q        <= a_buf;
				len_q        <= a_len;
				ovf_q        <= a_ovf;
				letter_q     <= closing ? gclp_pkg::NO_LETTER : a_letter;
				num_q        <= a_num;
				neg_q        <= a_neg;
				acc_q        <= a_acc;
				mask_q       <= mask_d;
				for (int k = 0; k < NL; k++) begin
					vals_q[k] <= vals_d[k];
				end
			end
		end
	end

endmodule

[design/gcode_line_parser_unit.sv]
// An accepted end-of-line byte is registered in byte_s1, and its record is then registered in rec_q.
// Throughput: one byte per cycle while byte_stall is low; the lexer state updates once per byte.
// A record waiting under stall holds back only an end-of-line byte.
// Reset (arst_n low) clears all line state and both valid flags.
// ----------------------------------------------------------------------------
// G-code line parser
// Byte-stream lexer for one G-code line, emitting one parsed record per line.
// ----------------------------------------------------------------------------
module gcode_line_parser_unit #(
	parameter int VALUE_WIDTH = gclp_pkg::VALUE_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  gclp_pkg::char_item_t byte_data,
	output logic                 rec_valid,
	input  logic                 rec_stall,
	output gclp_pkg::record_t    rec_data
);

	gclp_pkg::char_item_t byte_s1;
	logic                 byte_valid_s1;
	gclp_pkg::record_t    rec_q;
	logic                 rec_valid_q;

	gclp_pkg::name_info_t name;
	logic [3:0]           cmd_index;
	gclp_pkg::record_t    record;
	logic                 s1_go;
	logic                 step;
	logic                 take;

	assign s1_go      = !byte_s1.end_of_line || !rec_valid_q || !rec_stall;
	assign step       = byte_valid_s1 && s1_go;
	assign byte_stall = byte_valid_s1 && !s1_go;
	assign take       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (take) begin
			byte_valid_s1 <= 1'b1;
		end else if (s1_go) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= byte_data;
		end
	end

	gclp_lexer #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (byte_s1),
		.cmd_index(cmd_index),
		.name     (name),
		.record   (record)
	);

	gclp_cmd_match u_match (
		.name     (name),
		.cmd_index(cmd_index)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (step && byte_s1.end_of_line) begin
			rec_valid_q <= 1'b1;
		end else if (!rec_stall) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && byte_s1.end_of_line) begin
			rec_q <= record;
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec_data  = rec_q;

`ifndef NO_ASSERTIONS
	a_recognized: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> (rec_data.recognized == (rec_data.command_index != gclp_pkg::UNKNOWN_INDEX)))
		else $error("recognized flag disagrees with command index");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && !rec_data.used_mask[0]) |-> (rec_data.x_value == 32'sd0))
		else $error("absent X parameter carries a value");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (byte_valid_s1 && byte_s1.end_of_line && rec_valid && rec_stall))
		else $error("input stalled without a blocked record");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && rec_stall) |-> !step || !byte_s1.end_of_line)
		else $error("waiting record would be overwritten");
`endif

endmodule
